/* rtl/core/sfdm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfdm_pkg
// Shared types and constants of the stereo feedback delay mixer.
// ----------------------------------------------------------------------------
package sfdm_pkg;

    // register field widths
    localparam int MIX_W      = 16;
    localparam int FB_W       = 15;
    localparam int DELAY_W    = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // q1.15 gain scaling: round half up, then floor shift
    localparam int Q_SHIFT    = 15;
    localparam int Q_ROUND    = 16384;

    // register reset values
    localparam logic               RST_ENABLE   = 1'b1;
    localparam logic               RST_WET_ONLY = 1'b0;
    localparam logic [MIX_W-1:0]   RST_MIX      = 16'd16384;
    localparam logic [FB_W-1:0]    RST_FB       = 15'd8192;
    localparam logic [DELAY_W-1:0] RST_DELAY    = 14'd2400;
    localparam int                 RST_DELAY_I  = 2400;

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE   = 3'd0,
        CFG_WET_ONLY = 3'd1,
        CFG_MIX      = 3'd2,
        CFG_FEEDBACK = 3'd3,
        CFG_DELAY    = 3'd4
    } t_cfg_idx;

    // configuration register set
    typedef struct packed {
        logic               enable;
        logic               wet_only;
        logic [MIX_W-1:0]   mix_gain;
        logic [FB_W-1:0]    feedback_gain;
        logic [DELAY_W-1:0] delay_samples;
    } t_cfg;

    // pipeline control from the address unit to the lanes
    typedef struct packed {
        logic advance;     // whole pipeline moves this edge
        logic s1_ok;       // read entry has been written since reset
        logic fwd_s2;      // read entry is the pending write in stage 2
        logic fwd_lw;      // read entry is the last completed write
        logic s2_valid;    // stage 2 holds a word
        logic s2_active;   // stage 2 word is processed, not bypassed
        logic s2_wen;      // stage 2 word writes the delay memory
    } t_lane_ctl;

endpackage

/* rtl/core/sfdm_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfdm_in_if
// Input sample channel: one stereo pair per word.
// ----------------------------------------------------------------------------
interface sfdm_in_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

/* rtl/core/sfdm_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfdm_out_if
// Output sample channel: one stereo pair and a clip flag per word.
// ----------------------------------------------------------------------------
interface sfdm_out_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          clipped;

    modport source (output valid, output left_out, output right_out, output clipped,
                    input ready);
    modport sink   (input valid, input left_out, input right_out, input clipped,
                    output ready);
endinterface

/* rtl/core/sfdm_cfg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfdm_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface sfdm_cfg_if
    import sfdm_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/sfdm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfdm_ram
// Simple dual port RAM, one write and one registered read port, read-first.
// ----------------------------------------------------------------------------
module sfdm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/core/sfdm_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfdm_ctrl
// Configuration registers, delay modulo unit, write/read position tracking
// and the address side of the lane pipeline (forwarding compares).
// ----------------------------------------------------------------------------
module sfdm_ctrl
    import sfdm_pkg::*;
#(
    parameter int DELAY_DEPTH = 16384
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    sfdm_cfg_if.sink                       i_cfg_ch,
    input  logic                           i_advance,
    input  logic                           i_accept,
    output t_cfg                           o_cfg,
    output logic                           o_busy,
    output t_lane_ctl                      o_ctl,
    output logic [$clog2(DELAY_DEPTH)-1:0] o_raddr,
    output logic [$clog2(DELAY_DEPTH)-1:0] o_waddr
);
    localparam int AW     = $clog2(DELAY_DEPTH);
    localparam int SH     = 20;
    localparam int RECIP  = (1 << SH) / DELAY_DEPTH;
    localparam int RW     = $clog2(RECIP + 1);
    localparam int MW     = (DELAY_W + 1 > AW + 1) ? DELAY_W + 1 : AW + 1;
    localparam logic [AW-1:0]  LAST_POS  = AW'(DELAY_DEPTH - 1);
    localparam logic [AW:0]    DEPTH_A   = (AW + 1)'(DELAY_DEPTH);
    localparam logic [MW-1:0]  DEPTH_M   = MW'(DELAY_DEPTH);
    localparam logic [RW-1:0]  RECIP_V   = RW'(RECIP);
    localparam logic [AW-1:0]  RST_DMOD  = AW'(RST_DELAY_I % DELAY_DEPTH);

    t_cfg                  r_cfg;
    logic [1:0]            r_busy;
    logic [DELAY_W-1:0]    r_q;
    logic [MW-1:0]         r_rem;
    logic [AW-1:0]         r_dmod;
    logic [DELAY_W+RW-1:0] w_qprod;
    logic [MW+DELAY_W-1:0] w_qd;

    logic [AW-1:0] r_wr;
    logic          r_wrapped;
    logic [AW-1:0] w_rd;
    logic          w_ok;

    logic          r_s1_valid;
    logic          r_s1_active;
    logic          r_s1_ok;
    logic [AW-1:0] r_s1_rd;
    logic [AW-1:0] r_s1_wr;
    logic          r_s2_valid;
    logic          r_s2_active;
    logic [AW-1:0] r_s2_wr;
    logic          r_lw_valid;
    logic [AW-1:0] r_lw_addr;

    // register writes, busy window while the delay modulo settles
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable        <= RST_ENABLE;
            r_cfg.wet_only      <= RST_WET_ONLY;
            r_cfg.mix_gain      <= RST_MIX;
            r_cfg.feedback_gain <= RST_FB;
            r_cfg.delay_samples <= RST_DELAY;
            r_busy              <= 2'd0;
        end else begin
            if (i_cfg_ch.valid && (t_cfg_idx'(i_cfg_ch.index) == CFG_DELAY)) begin
                r_busy <= 2'd3;
            end else if (r_busy != 2'd0) begin
                r_busy <= r_busy - 2'd1;
            end
            if (i_cfg_ch.valid) begin
                unique case (t_cfg_idx'(i_cfg_ch.index))
                    CFG_ENABLE:   r_cfg.enable        <= i_cfg_ch.data[0];
                    CFG_WET_ONLY: r_cfg.wet_only      <= i_cfg_ch.data[0];
                    CFG_MIX:      r_cfg.mix_gain      <= i_cfg_ch.data[MIX_W-1:0];
                    CFG_FEEDBACK: r_cfg.feedback_gain <= i_cfg_ch.data[FB_W-1:0];
                    CFG_DELAY:    r_cfg.delay_samples <= i_cfg_ch.data[DELAY_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign i_cfg_ch.ready = 1'b1;

    // delay modulo depth: reciprocal estimate, then one correction
    assign w_qprod = (DELAY_W + RW)'(r_cfg.delay_samples) * (DELAY_W + RW)'(RECIP_V);
    assign w_qd    = (MW + DELAY_W)'(r_q) * (MW + DELAY_W)'(DEPTH_M);

    always_ff @(posedge i_clk) begin
        r_q   <= DELAY_W'(w_qprod >> SH);
        r_rem <= MW'(r_cfg.delay_samples) - MW'(w_qd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dmod <= RST_DMOD;
        end else if (r_busy == 2'd1) begin
            r_dmod <= AW'((r_rem >= DEPTH_M) ? r_rem - DEPTH_M : r_rem);
        end
    end

    // read position and whether that entry was written since reset
    always_comb begin
        if (r_wr >= r_dmod) begin
            w_rd = r_wr - r_dmod;
        end else begin
            w_rd = AW'({1'b0, r_wr} + DEPTH_A - {1'b0, r_dmod});
        end
        w_ok = r_wrapped || ((r_wr >= r_dmod) && (r_dmod != '0));
    end

    // write position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr      <= '0;
            r_wrapped <= 1'b0;
        end else if (i_accept && r_cfg.enable) begin
            if (r_wr == LAST_POS) begin
                r_wr      <= '0;
                r_wrapped <= 1'b1;
            end else begin
                r_wr <= r_wr + 1'b1;
            end
        end
    end

    // pipeline valid bits and last completed write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s1_active <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s2_active <= 1'b0;
            r_lw_valid  <= 1'b0;
        end else if (i_advance) begin
            r_s1_valid  <= i_accept;
            r_s1_active <= i_accept && r_cfg.enable;
            r_s2_valid  <= r_s1_valid;
            r_s2_active <= r_s1_active;
            if (r_s2_valid && r_s2_active) begin
                r_lw_valid <= 1'b1;
            end
        end
    end

    // pipeline addresses
    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_s1_rd <= w_rd;
            r_s1_wr <= r_wr;
            r_s1_ok <= w_ok;
            r_s2_wr <= r_s1_wr;
            if (r_s2_valid && r_s2_active) begin
                r_lw_addr <= r_s2_wr;
            end
        end
    end

    // lane control
    always_comb begin
        o_ctl.advance   = i_advance;
        o_ctl.s1_ok     = r_s1_ok;
        o_ctl.fwd_s2    = r_s2_valid && r_s2_active && (r_s2_wr == r_s1_rd);
        o_ctl.fwd_lw    = r_lw_valid && (r_lw_addr == r_s1_rd);
        o_ctl.s2_valid  = r_s2_valid;
        o_ctl.s2_active = r_s2_active;
        o_ctl.s2_wen    = r_s2_valid && r_s2_active && i_advance;
    end

    assign o_cfg   = r_cfg;
    assign o_busy  = (r_busy != 2'd0);
    assign o_raddr = w_rd;
    assign o_waddr = r_s2_wr;
endmodule

/* rtl/core/sfdm_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfdm_lane
// One channel of the feedback delay: delay memory, forwarding, feedback
// write-back and wet/dry output with saturation.
// ----------------------------------------------------------------------------
module sfdm_lane
    import sfdm_pkg::*;
#(
    parameter int DELAY_DEPTH = 16384,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                           i_clk,
    input  t_lane_ctl                      i_ctl,
    input  t_cfg                           i_cfg,
    input  logic [$clog2(DELAY_DEPTH)-1:0] i_raddr,
    input  logic [$clog2(DELAY_DEPTH)-1:0] i_waddr,
    input  logic signed [SAMPLE_BITS-1:0]  i_sample,
    output logic signed [SAMPLE_BITS-1:0]  o_sample,
    output logic                           o_clip
);
    localparam int SB  = SAMPLE_BITS;
    localparam int FPW = SB + FB_W + 1;
    localparam int MPW = SB + MIX_W + 1;
    localparam int EW  = SB + 3;
    localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB - 1){1'b1}}};
    localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB - 1){1'b0}}};

    logic signed [SB-1:0]  w_rdata;
    logic signed [SB-1:0]  w_delayed;
    logic signed [FPW-1:0] w_fb_prod;
    logic signed [FPW-1:0] w_fb_rnd;
    logic signed [EW-1:0]  w_fb_sum;
    logic signed [MPW-1:0] w_mix_prod;
    logic signed [MPW-1:0] w_mix_rnd;
    logic signed [EW-1:0]  w_wet;
    logic signed [EW-1:0]  w_out_sum;

    logic signed [SB-1:0]  r_s1_x;
    logic signed [SB-1:0]  r_s2_x;
    logic signed [MPW-1:0] r_s2_mix;
    logic signed [SB-1:0]  r_s2_wdata;
    logic                  r_s2_fclip;
    logic signed [SB-1:0]  r_lw_data;

    function automatic logic clip_of(input logic signed [EW-1:0] v);
        return !((&v[EW-1:SB-1]) || (~|v[EW-1:SB-1]));
    endfunction

    function automatic logic signed [SB-1:0] sat_of(input logic signed [EW-1:0] v);
        if (clip_of(v)) begin
            return v[EW-1] ? S_MIN : S_MAX;
        end
        return v[SB-1:0];
    endfunction

    // delay memory
    sfdm_ram #(
        .WIDTH (SB),
        .DEPTH (DELAY_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.s2_wen),
        .i_waddr (i_waddr),
        .i_wdata (r_s2_wdata),
        .i_re    (i_ctl.advance),
        .i_raddr (i_raddr),
        .o_rdata (w_rdata)
    );

    // delayed sample: pending write, last write, memory, or cleared entry
    always_comb begin
        priority if (i_ctl.fwd_s2) begin
            w_delayed = r_s2_wdata;
        end else if (i_ctl.fwd_lw) begin
            w_delayed = r_lw_data;
        end else if (i_ctl.s1_ok) begin
            w_delayed = w_rdata;
        end else begin
            w_delayed = '0;
        end
    end

    // stage 1: feedback write value and wet product
    always_comb begin
        w_fb_prod  = FPW'(w_delayed) * FPW'(signed'({1'b0, i_cfg.feedback_gain}));
        w_fb_rnd   = w_fb_prod + FPW'(Q_ROUND);
        w_fb_sum   = EW'(r_s1_x) + EW'(signed'(w_fb_rnd[FPW-1:Q_SHIFT]));
        w_mix_prod = MPW'(w_delayed) * MPW'(signed'({1'b0, i_cfg.mix_gain}));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            r_s1_x     <= i_sample;
            r_s2_x     <= r_s1_x;
            r_s2_mix   <= w_mix_prod;
            r_s2_wdata <= sat_of(w_fb_sum);
            r_s2_fclip <= clip_of(w_fb_sum);
        end
    end

    // copy of the last completed write for forwarding
    always_ff @(posedge i_clk) begin
        if (i_ctl.s2_wen) begin
            r_lw_data <= r_s2_wdata;
        end
    end

    // stage 2: wet/dry output, bypass passes the input
    always_comb begin
        w_mix_rnd = r_s2_mix + MPW'(Q_ROUND);
        w_wet     = EW'(signed'(w_mix_rnd[MPW-1:Q_SHIFT]));
        w_out_sum = i_cfg.wet_only ? w_wet : w_wet + EW'(r_s2_x);
        if (i_ctl.s2_active) begin
            o_sample = sat_of(w_out_sum);
            o_clip   = r_s2_fclip || clip_of(w_out_sum);
        end else begin
            o_sample = r_s2_x;
            o_clip   = 1'b0;
        end
    end
endmodule

/* rtl/core/stereo_feedback_delay_mix_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_feedback_delay_mix_top
// Stereo feedback delay with wet/dry mix: two lanes share one address unit,
// the merge stage joins the lane results and clip flags into one word.
//
//   channel   | dir | handshake    | payload
//   i_in_ch   | in  | valid/ready  | left_sample, right_sample (Q1.23)
//   o_out_ch  | out | valid/ready  | left_out, right_out, clipped
//   i_cfg_ch  | in  | valid/ready  | index, data (always ready)
//
// One word per cycle while the output is not stalled and no delay write is
// pending; each word passes the memory read, feedback stage and output register.
// Short delays are served by forwarding from the two most recent writes.
// Reset is synchronous; the memories need no clearing pass, entries not yet
// written since reset read as zero. A delay write holds input ready low while
// the delay modulo is recomputed.
// A finished word waiting in the output register freezes the whole pipeline
// and holds input ready low until the word is taken.
// ----------------------------------------------------------------------------
module stereo_feedback_delay_mix_top
    import sfdm_pkg::*;
#(
    parameter int DELAY_DEPTH = 16384,
    parameter int SAMPLE_BITS = 24
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sfdm_in_if.sink    i_in_ch,
    sfdm_out_if.source o_out_ch,
    sfdm_cfg_if.sink   i_cfg_ch
);
    localparam int AW = $clog2(DELAY_DEPTH);

    t_cfg                         w_cfg;
    t_lane_ctl                    w_ctl;
    logic                         w_busy;
    logic                         w_advance;
    logic                         w_accept;
    logic [AW-1:0]                w_raddr;
    logic [AW-1:0]                w_waddr;
    logic signed [SAMPLE_BITS-1:0] w_left;
    logic signed [SAMPLE_BITS-1:0] w_right;
    logic                         w_left_clip;
    logic                         w_right_clip;

    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_left;
    logic signed [SAMPLE_BITS-1:0] r_right;
    logic                          r_clip;

    // pipeline moves when the output register is free or being drained
    assign w_advance     = !r_out_valid || o_out_ch.ready;
    assign i_in_ch.ready = w_advance && !w_busy;
    assign w_accept      = i_in_ch.valid && i_in_ch.ready;

    // address unit and registers
    sfdm_ctrl #(
        .DELAY_DEPTH (DELAY_DEPTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_ch  (i_cfg_ch),
        .i_advance (w_advance),
        .i_accept  (w_accept),
        .o_cfg     (w_cfg),
        .o_busy    (w_busy),
        .o_ctl     (w_ctl),
        .o_raddr   (w_raddr),
        .o_waddr   (w_waddr)
    );

    // left lane
    sfdm_lane #(
        .DELAY_DEPTH (DELAY_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_left (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_cfg    (w_cfg),
        .i_raddr  (w_raddr),
        .i_waddr  (w_waddr),
        .i_sample (i_in_ch.left_sample),
        .o_sample (w_left),
        .o_clip   (w_left_clip)
    );

    // right lane
    sfdm_lane #(
        .DELAY_DEPTH (DELAY_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_right (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_cfg    (w_cfg),
        .i_raddr  (w_raddr),
        .i_waddr  (w_waddr),
        .i_sample (i_in_ch.right_sample),
        .o_sample (w_right),
        .o_clip   (w_right_clip)
    );

    // merge stage: output register and combined clip flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_ctl.s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_left  <= w_left;
            r_right <= w_right;
            r_clip  <= w_left_clip || w_right_clip;
        end
    end

    assign o_out_ch.valid     = r_out_valid;
    assign o_out_ch.left_out  = r_left;
    assign o_out_ch.right_out = r_right;
    assign o_out_ch.clipped   = r_clip;
endmodule
